[src/ocr_pkg.sv]
package ocr_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  // CORDIC datapath width, Q2.30 with headroom.
  localparam int CW = 34;
  // Width used for saturation to 32 bits.
  localparam int SATW = 80;

  localparam logic signed [CW-1:0] KINV_Q30 = 34'sd652032874;
  localparam logic signed [25:0] DEG2RAD_Q30 = 26'sd18740330;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] angle_deg;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] new_eye_x;
    logic signed [31:0] new_eye_y;
    logic signed [31:0] new_eye_z;
    logic signed [31:0] new_up_x;
    logic signed [31:0] new_up_y;
    logic signed [31:0] new_up_z;
    logic              degenerate_axis;
  } res_t;

  function automatic logic signed [CW-1:0] atan_q30(input int idx);
    logic signed [CW-1:0] r;
    case (idx)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      24: r = 34'sd64;
      25: r = 34'sd32;
      26: r = 34'sd16;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [31:0] r;
    if (v > 80'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -80'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/ocr_delay.sv]
module ocr_delay #(
  parameter int W = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  assign q = pipe[DEPTH-1];

endmodule

[src/ocr_cordic_cell.sv]
module ocr_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ocr_pkg::CW-1:0] x_in,
  input  logic signed [ocr_pkg::CW-1:0] y_in,
  input  logic signed [ocr_pkg::CW-1:0] z_in,
  output logic signed [ocr_pkg::CW-1:0] x_out,
  output logic signed [ocr_pkg::CW-1:0] y_out,
  output logic signed [ocr_pkg::CW-1:0] z_out
);

  localparam logic signed [ocr_pkg::CW-1:0] ATAN = ocr_pkg::atan_q30(STAGE);

  logic signed [ocr_pkg::CW-1:0] dx;
  logic signed [ocr_pkg::CW-1:0] dy;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ocr_pkg::CW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN;
      end
    end
  end

endmodule

[src/ocr_norm_cell.sv]
module ocr_norm_cell #(
  parameter int VW = 49,
  parameter bit LEFT = 1'b0
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0][VW-1:0]  v_in,
  output logic [2:0][VW-1:0]  v_out
);

  localparam logic signed [VW-1:0] HI = VW'(64'sd1 <<< 30);
  localparam logic signed [VW-1:0] LO = VW'(64'sd1 <<< 29);

  logic                big;
  logic                small_all;
  logic [2:0][VW-1:0]  v_nx;

  // A right cell halves the vector while any magnitude reaches 2^30; a left
  // cell doubles it while every magnitude stays below 2^29.
  always_comb begin
    big = 1'b0;
    small_all = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ($signed(v_in[i]) >= HI || $signed(v_in[i]) <= -HI) begin
        big = 1'b1;
      end
      if (!($signed(v_in[i]) < LO && $signed(v_in[i]) > -LO)) begin
        small_all = 1'b0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (LEFT) begin
        v_nx[i] = small_all ? (v_in[i] << 1) : v_in[i];
      end else begin
        v_nx[i] = big ? VW'($signed(v_in[i]) >>> 1) : v_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= v_nx;
    end
  end

endmodule

[src/ocr_sqrt_cell.sv]
module ocr_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_in,
  input  logic [63:0] r_in,
  output logic [63:0] n_out,
  output logic [63:0] r_out
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] t;

  assign t = r_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n_in >= t) begin
        n_out <= n_in - t;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        n_out <= n_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

[src/ocr_div_cell.sv]
module ocr_div_cell #(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [31:0]      den_in,
  input  logic [2:0][63:0] rem_in,
  input  logic [2:0][30:0] quo_in,
  output logic [31:0]      den_out,
  output logic [2:0][63:0] rem_out,
  output logic [2:0][30:0] quo_out
);

  logic [63:0]      dsh;
  logic [2:0][63:0] rem_nx;
  logic [2:0][30:0] quo_nx;

  assign dsh = 64'(den_in) << BIT;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo_nx[i] = quo_in[i];
      if (rem_in[i] >= dsh) begin
        rem_nx[i] = rem_in[i] - dsh;
        quo_nx[i][BIT] = 1'b1;
      end else begin
        rem_nx[i] = rem_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      rem_out <= rem_nx;
      quo_out <= quo_nx;
    end
  end

endmodule

[src/orbit_camera_rotation_top.sv]
// Orbit camera rotation: each item carries a mode, an angle in degrees and
// the eye and up vectors, all signed fixed point with FRAC_BITS fraction
// bits. Left mode rotates the eye about the up vector as given; up mode
// rotates both about the normalized eye x up axis, and flags a zero axis by
// passing the vectors through unchanged. The block is a fully pipelined row
// of cells and takes one item every clock cycle. Its depth is set by the
// axis normalization: the shift cells, the 32 square root cells and the 31
// divider cells, one result bit per cell. When a result is not taken the
// whole pipeline holds and req_ready drops.
module orbit_camera_rotation_top #(
  parameter int CORDIC_STAGES = ocr_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS = ocr_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ocr_pkg::req_t req_item,
  output logic          res_valid,
  input  logic          res_ready,
  output ocr_pkg::res_t res_item
);

  localparam int F = FRAC_BITS;
  localparam int N = CORDIC_STAGES;
  localparam int CW = ocr_pkg::CW;
  localparam int SATW = ocr_pkg::SATW;
  localparam int UW = 33 - F;
  localparam int RCW = 28;
  localparam int RSH = 36;
  localparam int QEW = UW + RCW - RSH;
  localparam int K360 = ((1 << (31 - F)) + 359) / 360;
  localparam int U_OFF = 360 * K360;
  localparam longint RECIP_L = ((64'sd1 <<< RSH) + 359) / 360;
  localparam logic [RCW-1:0] RECIP = RCW'(RECIP_L);
  localparam int RW = F + 10;
  localparam int ZPW = RW + 26;
  localparam int CSW = F + 3;
  localparam int VW = 65 - F;
  localparam int RC = VW - 30;
  localparam int LC = 29;
  localparam int NC = RC + LC;
  localparam int ANG_DONE = N + 4;
  localparam int V_DONE = 2 + NC;
  localparam int LEN_DONE = V_DONE + 34;
  localparam int AX_DONE = LEN_DONE + 32;
  localparam int D = AX_DONE + 6;
  localparam int SAW = CSW + 32 - F;
  localparam int EW = 33 + CSW;
  localparam int MW = 40;

  localparam logic signed [RW-1:0] FULL_D = RW'(64'sd360 <<< F);
  localparam logic signed [RW-1:0] HALF_D = RW'(64'sd180 <<< F);
  localparam logic signed [RW-1:0] QUAR_D = RW'(64'sd90 <<< F);
  localparam logic signed [CW-1:0] RND_CS = CW'(64'sd1 <<< (29 - F));
  localparam logic signed [CSW:0] ONE_F = (CSW + 1)'(64'sd1 <<< F);
  localparam logic signed [31:0] RND_AX = 32'(64'sd1 <<< (29 - F));

  logic          en;
  logic [D:0]    vld;
  ocr_pkg::req_t in_q;

  assign en = !vld[D] || res_ready;
  assign req_ready = en && !rst;
  assign res_valid = vld[D];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-1:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_q <= req_item;
    end
  end

  // Angle reduction.
  logic signed [31:0]     deg;
  logic signed [31:0]     qhi;
  logic signed [32:0]     u_wide;
  logic [UW-1:0]          u_q;
  logic [UW+RCW-1:0]      a1_prod;
  logic [UW-1:0]          a1_u;
  logic [F-1:0]           a1_f;
  logic [QEW-1:0]         qe;
  logic [UW-1:0]          rem_w;
  logic signed [RW-1:0]   r_a;
  logic signed [RW-1:0]   r_b;
  logic signed [RW-1:0]   r_c;
  logic                   r_neg;
  logic signed [RW-1:0]   a2_r;
  logic                   a2_neg;
  logic signed [ZPW-1:0]  a3_zp;

  assign deg = in_q.angle_deg;
  assign qhi = deg >>> F;
  assign u_wide = 33'(qhi) + 33'(U_OFF);
  assign u_q = u_wide[UW-1:0];
  assign qe = a1_prod[UW+RCW-1:RSH];
  assign rem_w = a1_u - UW'(qe) * UW'(10'd360);
  assign r_a = $signed({1'b0, rem_w[8:0], a1_f});

  always_comb begin
    r_b = (r_a >= HALF_D) ? r_a - FULL_D : r_a;
    r_c = r_b;
    r_neg = 1'b0;
    if (r_b > QUAR_D) begin
      r_c = r_b - HALF_D;
      r_neg = 1'b1;
    end else if (r_b < -QUAR_D) begin
      r_c = r_b + HALF_D;
      r_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_prod <= u_q * RECIP;
      a1_u <= u_q;
      a1_f <= deg[F-1:0];
      a2_r <= r_c;
      a2_neg <= r_neg;
      a3_zp <= a2_r * ocr_pkg::DEG2RAD_Q30;
    end
  end

  // CORDIC row.
  logic signed [CW-1:0] cx [N+1];
  logic signed [CW-1:0] cy [N+1];
  logic signed [CW-1:0] cz [N+1];
  logic                 cneg;
  logic signed [CW-1:0] xn;
  logic signed [CW-1:0] yn;
  logic signed [CW-1:0] xr;
  logic signed [CW-1:0] yr;
  logic signed [CSW-1:0] ang_c;
  logic signed [CSW-1:0] ang_s;

  assign cx[0] = ocr_pkg::KINV_Q30;
  assign cy[0] = '0;
  assign cz[0] = CW'(a3_zp >>> F);

  for (genvar k = 0; k < N; k++) begin : g_cordic
    ocr_cordic_cell #(.STAGE(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (cx[k]),
      .y_in  (cy[k]),
      .z_in  (cz[k]),
      .x_out (cx[k+1]),
      .y_out (cy[k+1]),
      .z_out (cz[k+1])
    );
  end

  ocr_delay #(.W(1), .DEPTH(N + 1)) u_neg_dly (
    .clk (clk),
    .en  (en),
    .d   (a2_neg),
    .q   (cneg)
  );

  assign xn = cneg ? -cx[N] : cx[N];
  assign yn = cneg ? -cy[N] : cy[N];
  assign xr = (xn + RND_CS) >>> (30 - F);
  assign yr = (yn + RND_CS) >>> (30 - F);

  always_ff @(posedge clk) begin
    if (en) begin
      ang_c <= CSW'(xr);
      ang_s <= CSW'(yr);
    end
  end

  // Cross product and normalization.
  logic signed [31:0] ev0 [3];
  logic signed [31:0] uv0 [3];
  logic signed [63:0] n1_p [6];
  logic signed [64:0] n2_d [3];
  logic [2:0][VW-1:0] n2_v;
  logic               n2_zero;
  logic [2:0][VW-1:0] nv [NC+1];
  logic signed [30:0] vn [3];
  logic [61:0]        sq [3];
  logic [63:0]        ssum;
  logic [63:0]        sn [33];
  logic [63:0]        sr [33];
  logic [2:0][30:0]   vn_pk;
  logic [2:0][30:0]   vd;
  logic [2:0][30:0]   vmag;
  logic [2:0]         vsgn;
  logic [31:0]        dd [32];
  logic [2:0][63:0]   rm [32];
  logic [2:0][30:0]   qq [32];
  logic signed [31:0] nq [3];
  logic signed [31:0] ax [3];

  assign ev0[0] = in_q.eye_x;
  assign ev0[1] = in_q.eye_y;
  assign ev0[2] = in_q.eye_z;
  assign uv0[0] = in_q.up_x;
  assign uv0[1] = in_q.up_y;
  assign uv0[2] = in_q.up_z;

  assign n2_d[0] = 65'(n1_p[0] >>> F) - 65'(n1_p[1] >>> F);
  assign n2_d[1] = 65'(n1_p[2] >>> F) - 65'(n1_p[3] >>> F);
  assign n2_d[2] = 65'(n1_p[4] >>> F) - 65'(n1_p[5] >>> F);

  always_ff @(posedge clk) begin
    if (en) begin
      n1_p[0] <= ev0[1] * uv0[2];
      n1_p[1] <= ev0[2] * uv0[1];
      n1_p[2] <= ev0[2] * uv0[0];
      n1_p[3] <= ev0[0] * uv0[2];
      n1_p[4] <= ev0[0] * uv0[1];
      n1_p[5] <= ev0[1] * uv0[0];
      for (int i = 0; i < 3; i++) begin
        n2_v[i] <= n2_d[i][VW-1:0];
      end
      n2_zero <= (n2_d[0] == '0) && (n2_d[1] == '0) && (n2_d[2] == '0);
    end
  end

  assign nv[0] = n2_v;

  for (genvar k = 0; k < NC; k++) begin : g_norm
    ocr_norm_cell #(.VW(VW), .LEFT(k >= RC)) u_cell (
      .clk   (clk),
      .en    (en),
      .v_in  (nv[k]),
      .v_out (nv[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vn[i] = $signed(nv[NC][i][30:0]);
      vn_pk[i] = nv[NC][i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= 62'(vn[i] * vn[i]);
      end
      ssum <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
    end
  end

  assign sn[0] = ssum;
  assign sr[0] = '0;

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    ocr_sqrt_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .n_in  (sn[k]),
      .r_in  (sr[k]),
      .n_out (sn[k+1]),
      .r_out (sr[k+1])
    );
  end

  ocr_delay #(.W(93), .DEPTH(34)) u_v_dly (
    .clk (clk),
    .en  (en),
    .d   (vn_pk),
    .q   (vd)
  );

  ocr_delay #(.W(3), .DEPTH(31)) u_sgn_dly (
    .clk (clk),
    .en  (en),
    .d   ({vd[2][30], vd[1][30], vd[0][30]}),
    .q   (vsgn)
  );

  assign dd[0] = sr[32][31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i] = vd[i][30] ? 31'(-vd[i]) : vd[i];
      rm[0][i] = {3'b000, vmag[i], 30'd0};
      qq[0][i] = '0;
    end
  end

  for (genvar k = 0; k < 31; k++) begin : g_div
    ocr_div_cell #(.BIT(30 - k)) u_cell (
      .clk     (clk),
      .en      (en),
      .den_in  (dd[k]),
      .rem_in  (rm[k]),
      .quo_in  (qq[k]),
      .den_out (dd[k+1]),
      .rem_out (rm[k+1]),
      .quo_out (qq[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq[i] = vsgn[i] ? -$signed({1'b0, qq[31][i]}) : $signed({1'b0, qq[31][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ax[i] <= (nq[i] + RND_AX) >>> (30 - F);
      end
    end
  end

  // Alignment of the item, the zero flag and cos/sin with the axis.
  ocr_pkg::req_t         it_ax;
  ocr_pkg::req_t         it_m4;
  ocr_pkg::req_t         it_m5;
  logic                  zero_d;
  logic signed [CSW-1:0] cs_c;
  logic signed [CSW-1:0] cs_s;

  ocr_delay #(.W($bits(ocr_pkg::req_t)), .DEPTH(AX_DONE)) u_it_dly (
    .clk (clk),
    .en  (en),
    .d   (in_q),
    .q   (it_ax)
  );

  ocr_delay #(.W($bits(ocr_pkg::req_t)), .DEPTH(4)) u_it4_dly (
    .clk (clk),
    .en  (en),
    .d   (it_ax),
    .q   (it_m4)
  );

  ocr_delay #(.W($bits(ocr_pkg::req_t)), .DEPTH(1)) u_it5_dly (
    .clk (clk),
    .en  (en),
    .d   (it_m4),
    .q   (it_m5)
  );

  ocr_delay #(.W(1), .DEPTH(AX_DONE + 3)) u_zero_dly (
    .clk (clk),
    .en  (en),
    .d   (n2_zero),
    .q   (zero_d)
  );

  ocr_delay #(.W(2 * CSW), .DEPTH(AX_DONE - ANG_DONE)) u_cs_dly (
    .clk (clk),
    .en  (en),
    .d   ({ang_c, ang_s}),
    .q   ({cs_c, cs_s})
  );

  // Rotation matrix and its application.
  logic signed [31:0]       av [3];
  logic signed [CSW+31:0]   m1_sa [3];
  logic signed [63:0]       m1_aa [6];
  logic signed [CSW:0]      m1_omc;
  logic signed [CSW-1:0]    m1_c;
  logic signed [31:0]       m2_p [6];
  logic signed [SAW-1:0]    m2_sa [3];
  logic signed [CSW:0]      m2_omc;
  logic signed [CSW-1:0]    m2_c;
  logic signed [EW-1:0]     m3_e [6];
  logic signed [SAW-1:0]    m3_sa [3];
  logic signed [CSW-1:0]    m3_c;
  logic signed [MW-1:0]     ew [6];
  logic signed [MW-1:0]     saw [3];
  logic signed [MW-1:0]     cw;
  logic signed [MW-1:0]     eb [3][3];
  logic signed [31:0]       m4_m [3][3];
  logic signed [31:0]       ev4 [3];
  logic signed [31:0]       uv4 [3];
  logic signed [63:0]       m5_pe [3][3];
  logic signed [63:0]       m5_pu [3][3];
  logic signed [31:0]       re [3];
  logic signed [31:0]       ru [3];
  ocr_pkg::res_t            res_nx;

  always_comb begin
    av[0] = it_ax.req_type ? ax[0] : it_ax.up_x;
    av[1] = it_ax.req_type ? ax[1] : it_ax.up_y;
    av[2] = it_ax.req_type ? ax[2] : it_ax.up_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_sa[i] <= av[i] * cs_s;
      end
      m1_aa[0] <= av[0] * av[0];
      m1_aa[1] <= av[1] * av[1];
      m1_aa[2] <= av[2] * av[2];
      m1_aa[3] <= av[0] * av[1];
      m1_aa[4] <= av[0] * av[2];
      m1_aa[5] <= av[1] * av[2];
      m1_omc <= ONE_F - (CSW + 1)'(cs_c);
      m1_c <= cs_c;
      for (int k = 0; k < 6; k++) begin
        m2_p[k] <= ocr_pkg::sat32(SATW'(m1_aa[k] >>> F));
        m3_e[k] <= m2_p[k] * m2_omc;
      end
      for (int i = 0; i < 3; i++) begin
        m2_sa[i] <= SAW'(m1_sa[i] >>> F);
        m3_sa[i] <= m2_sa[i];
      end
      m2_omc <= m1_omc;
      m2_c <= m1_c;
      m3_c <= m2_c;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ew[k] = MW'(m3_e[k] >>> F);
    end
    for (int i = 0; i < 3; i++) begin
      saw[i] = MW'(m3_sa[i]);
    end
    cw = MW'(m3_c);
    eb[0][0] = ew[0] + cw;
    eb[1][1] = ew[1] + cw;
    eb[2][2] = ew[2] + cw;
    eb[0][1] = ew[3] - saw[2];
    eb[1][0] = ew[3] + saw[2];
    eb[0][2] = ew[4] + saw[1];
    eb[2][0] = ew[4] - saw[1];
    eb[1][2] = ew[5] - saw[0];
    eb[2][1] = ew[5] + saw[0];
  end

  assign ev4[0] = it_m4.eye_x;
  assign ev4[1] = it_m4.eye_y;
  assign ev4[2] = it_m4.eye_z;
  assign uv4[0] = it_m4.up_x;
  assign uv4[1] = it_m4.up_y;
  assign uv4[2] = it_m4.up_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m4_m[i][j] <= ocr_pkg::sat32(SATW'(eb[i][j]));
          m5_pe[i][j] <= m4_m[i][j] * ev4[j];
          m5_pu[i][j] <= m4_m[i][j] * uv4[j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      re[i] = ocr_pkg::sat32(SATW'(m5_pe[i][0] >>> F) + SATW'(m5_pe[i][1] >>> F)
                             + SATW'(m5_pe[i][2] >>> F));
      ru[i] = ocr_pkg::sat32(SATW'(m5_pu[i][0] >>> F) + SATW'(m5_pu[i][1] >>> F)
                             + SATW'(m5_pu[i][2] >>> F));
    end
    res_nx.new_eye_x = re[0];
    res_nx.new_eye_y = re[1];
    res_nx.new_eye_z = re[2];
    res_nx.new_up_x = ru[0];
    res_nx.new_up_y = ru[1];
    res_nx.new_up_z = ru[2];
    res_nx.degenerate_axis = 1'b0;
    if (!it_m5.req_type) begin
      res_nx.new_up_x = it_m5.up_x;
      res_nx.new_up_y = it_m5.up_y;
      res_nx.new_up_z = it_m5.up_z;
    end else if (zero_d) begin
      res_nx.new_eye_x = it_m5.eye_x;
      res_nx.new_eye_y = it_m5.eye_y;
      res_nx.new_eye_z = it_m5.eye_z;
      res_nx.new_up_x = it_m5.up_x;
      res_nx.new_up_y = it_m5.up_y;
      res_nx.new_up_z = it_m5.up_z;
      res_nx.degenerate_axis = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_item <= res_nx;
    end
  end

endmodule

[verif/orbit_camera_rotation_top_test.sv]
module orbit_camera_rotation_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int STAGES = 16;
  localparam int LATENCY = 138 - FB;

  typedef longint signed q_t;

  function automatic q_t floor_shift(q_t v, int s);
    if (v >= 0) begin
      return v >>> s;
    end
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic q_t clamp32(q_t v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic q_t arctan_entry(int i);
    q_t t[32] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic q_t root64(q_t n_in);
    longint unsigned n, r, b;
    n = n_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return q_t'(r);
  endfunction

  class rotation_scoreboard;
    ocr_pkg::res_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void cos_sin(q_t deg, output q_t c, output q_t s);
      q_t one, full, half, quarter, r, x, y, z, dx, dy;
      bit flip;
      one = 64'sd1 <<< FB;
      full = 360 * one;
      half = 180 * one;
      quarter = 90 * one;
      r = deg % full;
      flip = 0;
      if (r < 0) r += full;
      if (r >= half) r -= full;
      if (r > quarter) begin
        r -= half;
        flip = 1;
      end else if (r < -quarter) begin
        r += half;
        flip = 1;
      end
      z = floor_shift(r * 18740330, FB);
      x = 652032874;
      y = 0;
      for (int i = 0; i < STAGES && i < 32; i++) begin
        dx = floor_shift(y, i);
        dy = floor_shift(x, i);
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= arctan_entry(i);
        end else begin
          x += dx;
          y -= dy;
          z += arctan_entry(i);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = floor_shift(x + (64'sd1 <<< (29 - FB)), 30 - FB);
      s = floor_shift(y + (64'sd1 <<< (29 - FB)), 30 - FB);
    endfunction

    function void rodrigues(q_t c, q_t s, q_t a[3], output q_t m[3][3]);
      q_t omc, sa[3], p;
      omc = (64'sd1 <<< FB) - c;
      for (int i = 0; i < 3; i++) sa[i] = floor_shift(s * a[i], FB);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p = clamp32(floor_shift(a[i] * a[j], FB));
          m[i][j] = floor_shift(p * omc, FB) + ((i == j) ? c : 0);
        end
      end
      m[0][1] -= sa[2]; m[0][2] += sa[1];
      m[1][0] += sa[2]; m[1][2] -= sa[0];
      m[2][0] -= sa[1]; m[2][1] += sa[0];
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i][j] = clamp32(m[i][j]);
    endfunction

    function void transform(q_t m[3][3], q_t v[3], output q_t o[3]);
      q_t acc;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += floor_shift(m[i][j] * v[j], FB);
        o[i] = clamp32(acc);
      end
    endfunction

    function q_t peak(q_t v[3]);
      q_t r, a;
      r = 0;
      for (int i = 0; i < 3; i++) begin
        a = v[i] < 0 ? -v[i] : v[i];
        if (a > r) r = a;
      end
      return r;
    endfunction

    function void note_request(ocr_pkg::req_t q);
      q_t e[3], u[3], ne[3], nu[3], ax[3], v[3], m[3][3], c, s, sum, len, n;
      ocr_pkg::res_t r;
      e = '{q.eye_x, q.eye_y, q.eye_z};
      u = '{q.up_x, q.up_y, q.up_z};
      ne = e;
      nu = u;
      r.degenerate_axis = 1'b0;
      cos_sin(q_t'(q.angle_deg), c, s);
      if (!q.req_type) begin
        rodrigues(c, s, u, m);
        transform(m, e, ne);
      end else begin
        v[0] = floor_shift(e[1] * u[2], FB) - floor_shift(e[2] * u[1], FB);
        v[1] = floor_shift(e[2] * u[0], FB) - floor_shift(e[0] * u[2], FB);
        v[2] = floor_shift(e[0] * u[1], FB) - floor_shift(e[1] * u[0], FB);
        if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
          r.degenerate_axis = 1'b1;
        end else begin
          while (peak(v) >= (64'sd1 <<< 30))
            for (int i = 0; i < 3; i++) v[i] = floor_shift(v[i], 1);
          while (peak(v) < (64'sd1 <<< 29))
            for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
          sum = 0;
          for (int i = 0; i < 3; i++) sum += v[i] * v[i];
          len = root64(sum);
          for (int i = 0; i < 3; i++) begin
            n = (v[i] * (64'sd1 <<< 30)) / len;
            ax[i] = floor_shift(n + (64'sd1 <<< (29 - FB)), 30 - FB);
          end
          rodrigues(c, s, ax, m);
          transform(m, e, ne);
          transform(m, u, nu);
        end
      end
      r.new_eye_x = ne[0][31:0];
      r.new_eye_y = ne[1][31:0];
      r.new_eye_z = ne[2][31:0];
      r.new_up_x = nu[0][31:0];
      r.new_up_y = nu[1][31:0];
      r.new_up_z = nu[2][31:0];
      pending.push_back(r);
    endfunction

    function void check_result(ocr_pkg::res_t got);
      ocr_pkg::res_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.new_eye_x !== w.new_eye_x) report("new_eye_x", w.new_eye_x, got.new_eye_x);
      if (got.new_eye_y !== w.new_eye_y) report("new_eye_y", w.new_eye_y, got.new_eye_y);
      if (got.new_eye_z !== w.new_eye_z) report("new_eye_z", w.new_eye_z, got.new_eye_z);
      if (got.new_up_x !== w.new_up_x) report("new_up_x", w.new_up_x, got.new_up_x);
      if (got.new_up_y !== w.new_up_y) report("new_up_y", w.new_up_y, got.new_up_y);
      if (got.new_up_z !== w.new_up_z) report("new_up_z", w.new_up_z, got.new_up_z);
      if (got.degenerate_axis !== w.degenerate_axis)
        report("degenerate_axis", {31'd0, w.degenerate_axis}, {31'd0, got.degenerate_axis});
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  ocr_pkg::req_t req_item = '0;
  logic res_valid;
  logic res_ready = 0;
  ocr_pkg::res_t res_item;

  rotation_scoreboard board = new();
  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;

  orbit_camera_rotation_top dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .req_item(req_item), .res_valid(res_valid), .res_ready(res_ready),
    .res_item(res_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) board.note_request(req_item);
    if (!rst && res_valid && res_ready) board.check_result(res_item);
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_ready <= 0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  task automatic offer(ocr_pkg::req_t q);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req_item <= q;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic offer_random(int count);
    ocr_pkg::req_t q;
    for (int k = 0; k < count; k++) begin
      q.req_type = 1'($urandom_range(1));
      q.angle_deg = ($urandom_range(3) == 0) ? $urandom : pick_word();
      q.eye_x = pick_word();
      q.eye_y = pick_word();
      q.eye_z = pick_word();
      q.up_x = pick_word();
      q.up_y = pick_word();
      q.up_z = pick_word();
      if ($urandom_range(9) == 0) begin
        q.up_x = q.eye_x;
        q.up_y = q.eye_y;
        q.up_z = q.eye_z;
      end
      offer(q);
    end
    req_valid <= 0;
  endtask

  task automatic offer_directed();
    logic signed [31:0] ang[8] = '{0, 32'sh005a0000, -32'sh005a0000, 32'sh00b40000,
      32'sh7fffffff, 32'sh80000000, 32'sh002d0000, 32'sh01680000};
    ocr_pkg::req_t q;
    for (int k = 0; k < 8; k++) begin
      q.req_type = k[0];
      q.angle_deg = ang[k];
      q.eye_x = 32'sh00050000; q.eye_y = 0; q.eye_z = 32'sh00020000;
      q.up_x = 0; q.up_y = 32'sh00010000; q.up_z = 0;
      offer(q);
    end
    q.req_type = 1;
    q.angle_deg = 32'sh001e0000;
    q.eye_x = 32'sh00010000; q.eye_y = 32'sh00020000; q.eye_z = 32'sh00030000;
    q.up_x = 32'sh00020000; q.up_y = 32'sh00040000; q.up_z = 32'sh00060000;
    offer(q);
    q.eye_x = 0; q.eye_y = 0; q.eye_z = 0;
    offer(q);
    q.req_type = 0;
    q.up_x = 0; q.up_y = 0; q.up_z = 0;
    q.eye_x = 32'sh7fffffff; q.eye_y = 32'sh80000000; q.eye_z = 32'sh12345678;
    offer(q);
    q.up_x = 32'sh7fffffff; q.up_y = 32'sh80000000; q.up_z = 32'sh7fffffff;
    offer(q);
    q.req_type = 1;
    offer(q);
    q.eye_x = 32'sh80000000; q.eye_y = 32'sh7fffffff; q.eye_z = 32'sh80000000;
    q.up_x = 32'sh00000001; q.up_y = 32'shffffffff; q.up_z = 32'sh00000001;
    offer(q);
    req_valid <= 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    offer_directed();
    offer_random(300);
    send_idle = 85;
    offer_random(250);
    send_idle = 0;
    recv_stall = 85;
    offer_random(250);
    send_idle = 31;
    recv_stall = 31;
    offer_random(250);
    send_idle = 0;
    recv_stall = 0;
    hold_cycles = 400;
    offer_random(300);
    send_idle = 50;
    recv_stall = 50;
    offer_random(150);
    recv_stall = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.errors == 0) begin
      $display("orbit_camera_rotation_top_test: clean");
    end else begin
      $display("orbit_camera_rotation_top_test: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("orbit_camera_rotation_top_test: errors");
    $finish;
  end
endmodule
